### rtl/fbpk_pkg.sv
package fbpk_pkg;

	localparam int IDX_W   = 11;
	localparam int S_W     = 32;
	localparam int PIQ_W   = 29;
	localparam int PROD_W  = S_W + PIQ_W;
	localparam int NSQ_W   = 21;
	localparam int D_W     = 22;
	localparam int Q_W     = 46;
	localparam int OUT_W   = 48;
	localparam int DEN_SHIFT = 16;
	localparam int RL_ZERO_SHIFT = 14;
	localparam int UNIT_SHIFT = 32;

	localparam logic [16:0] HALF_SPAN = 17'd1024;
	localparam logic [PIQ_W-1:0] PI_SQ_RECIP_Q32 = 29'd435171170;
	localparam logic [Q_W-1:0] ONE_Q32 = Q_W'(1) << UNIT_SHIFT;
	localparam logic [S_W-1:0] INV_INTERVAL_SQ_RESET = 32'd65536;

	typedef enum logic [1:0] {
		MODE_CONST       = 2'd0,
		MODE_RAM_LAK     = 2'd1,
		MODE_SHEPP_LOGAN = 2'd2
	} mode_t;

	typedef enum logic [0:0] {
		REG_FILTER_MODE     = 1'b0,
		REG_INV_INTERVAL_SQ = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic           neg;
		logic [D_W-1:0] d;
		logic [D_W-1:0] r;
		logic [Q_W-1:0] nq;
	} cell_t;

endpackage

### rtl/fbpk_prep.sv
module fbpk_prep (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             tap_valid,
	input  logic signed [fbpk_pkg::IDX_W-1:0] tap_index,
	input  fbpk_pkg::mode_t                  mode,
	input  logic [fbpk_pkg::S_W-1:0]         inv_interval_sq,
	output logic                             valid_s2,
	output fbpk_pkg::cell_t                  cell_s2
);
	import fbpk_pkg::*;

	logic [IDX_W-1:0]  an;
	logic [2*IDX_W-1:0] an_sq;

	logic              valid_s1;
	logic              zero_s1;
	logic              odd_s1;
	logic              outside_s1;
	mode_t             mode_s1;
	logic [NSQ_W-1:0]  nsq_s1;
	logic [S_W-1:0]    s_s1;
	logic [PROD_W-1:0] prod_s1;

	logic [D_W:0]      four_nsq_m1;
	logic [PROD_W:0]   num_base;
	logic [PROD_W+1:0] num_sum;
	logic              use_div;
	logic              neg;
	logic [D_W-1:0]    d;
	logic [Q_W-1:0]    n_direct;
	cell_t             cell_next;

	assign an    = tap_index[IDX_W-1] ? IDX_W'(-tap_index) : IDX_W'(tap_index);
	assign an_sq = (2*IDX_W)'(an) * (2*IDX_W)'(an);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= tap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1    <= (an == '0);
			odd_s1     <= an[0];
			outside_s1 <= (17'(an) >= HALF_SPAN);
			mode_s1    <= mode;
			nsq_s1     <= an_sq[NSQ_W-1:0];
			s_s1       <= inv_interval_sq;
			prod_s1    <= PROD_W'(inv_interval_sq) * PROD_W'(PI_SQ_RECIP_Q32);
		end
	end

	assign four_nsq_m1 = {nsq_s1, 2'b00} - (D_W+1)'(1);

	always_comb begin
		use_div  = 1'b0;
		neg      = 1'b0;
		d        = D_W'(1);
		n_direct = '0;
		if (!outside_s1) begin
			unique case (mode_s1)
				MODE_CONST: begin
					n_direct = zero_s1 ? ONE_Q32 : '0;
				end
				MODE_RAM_LAK: begin
					if (zero_s1) begin
						n_direct = Q_W'({s_s1, RL_ZERO_SHIFT'(0)});
					end else if (odd_s1) begin
						use_div = 1'b1;
						neg     = 1'b1;
						d       = D_W'(nsq_s1);
					end
				end
				MODE_SHEPP_LOGAN: begin
					use_div = 1'b1;
					neg     = !zero_s1;
					d       = zero_s1 ? D_W'(1) : four_nsq_m1[D_W-1:0];
				end
				default: begin
					n_direct = '0;
				end
			endcase
		end
	end

	// Shepp-Logan carries twice the product; the half divisor rounds to nearest.
	assign num_base = (mode_s1 == MODE_SHEPP_LOGAN) ? {prod_s1, 1'b0} : {1'b0, prod_s1};
	assign num_sum  = (PROD_W+2)'(num_base) + (PROD_W+2)'({d, (DEN_SHIFT-1)'(0)});

	always_comb begin
		cell_next.neg = neg;
		cell_next.d   = d;
		cell_next.r   = '0;
		cell_next.nq  = use_div ? num_sum[DEN_SHIFT +: Q_W] : n_direct;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_s2 <= cell_next;
		end
	end

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cell_s2.d != '0))
		else $error("Divisor entering the chain is zero.");

endmodule

### rtl/fbpk_div_cell.sv
module fbpk_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            prev_valid,
	input  fbpk_pkg::cell_t prev_data,
	output logic            valid,
	output fbpk_pkg::cell_t data
);
	import fbpk_pkg::*;

	logic [D_W:0] trial;
	logic [D_W:0] diff;
	logic         ge;
	cell_t        next;

	// One restoring step: bring down the next dividend bit and try the divisor.
	assign trial = {prev_data.r, prev_data.nq[Q_W-1]};
	assign diff  = trial - {1'b0, prev_data.d};
	assign ge    = (trial >= {1'b0, prev_data.d});

	always_comb begin
		next.neg = prev_data.neg;
		next.d   = prev_data.d;
		next.r   = ge ? diff[D_W-1:0] : trial[D_W-1:0];
		next.nq  = {prev_data.nq[Q_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (en) begin
			valid <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data <= next;
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (data.r < data.d))
		else $error("Partial remainder is not below the divisor.");

endmodule

### rtl/fbpk_out_buf.sv
module fbpk_out_buf (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pipe_valid,
	input  fbpk_pkg::cell_t                    pipe_data,
	output logic                               advance,
	output logic                               coef_valid,
	input  logic                               coef_ready,
	output logic signed [fbpk_pkg::OUT_W-1:0] coefficient
);
	import fbpk_pkg::*;

	logic             skid_valid_q;
	logic [OUT_W-1:0] skid_data_q;
	logic [OUT_W-1:0] mag;
	logic [OUT_W-1:0] coef_next;
	logic             incoming;

	assign mag       = OUT_W'(pipe_data.nq);
	assign coef_next = pipe_data.neg ? -mag : mag;
	assign advance   = !skid_valid_q;
	assign incoming  = advance && pipe_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_valid   <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!coef_valid || coef_ready) begin
			if (skid_valid_q) begin
				coef_valid   <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				coef_valid <= incoming;
			end
		end else if (incoming) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!coef_valid || coef_ready) begin
			coefficient <= skid_valid_q ? signed'(skid_data_q) : signed'(coef_next);
		end else if (incoming) begin
			skid_data_q <= coef_next;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> coef_valid)
		else $error("Skid entry held while the output register is empty.");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(coef_valid && !coef_ready))
		else $error("Skid entry filled without a stalled output.");

endmodule

### rtl/fbp_filter_kernel_gen.sv
// Stages: two set-up, a divider cell per quotient bit, one output register.
// Throughput: one request per cycle while the output skid entry is empty;
// a chain of 46 restoring divider cells produces one quotient bit each and
// all advance together.
// Reset: asynchronous, active low; it empties the pipeline and sets the
// filter mode to constant and the inverse interval squared to 1.0.
module fbp_filter_kernel_gen (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  fbpk_pkg::cfg_reg_t                 cfg_index,
	input  logic [fbpk_pkg::S_W-1:0]           cfg_data,
	input  logic                               tap_valid,
	output logic                               tap_ready,
	input  logic signed [fbpk_pkg::IDX_W-1:0]  tap_index,
	output logic                               coef_valid,
	input  logic                               coef_ready,
	output logic signed [fbpk_pkg::OUT_W-1:0]  coefficient
);
	import fbpk_pkg::*;

	mode_t          filter_mode_q;
	logic [S_W-1:0] inv_interval_sq_q;
	logic           advance;
	logic           chain_valid [0:Q_W];
	cell_t          chain_data  [0:Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q     <= MODE_CONST;
			inv_interval_sq_q <= INV_INTERVAL_SQ_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_MODE:     filter_mode_q     <= mode_t'(cfg_data[1:0]);
				REG_INV_INTERVAL_SQ: inv_interval_sq_q <= cfg_data;
				default:             filter_mode_q     <= filter_mode_q;
			endcase
		end
	end

	assign tap_ready = advance;

	fbpk_prep u_prep (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (advance),
		.tap_valid       (tap_valid),
		.tap_index       (tap_index),
		.mode            (filter_mode_q),
		.inv_interval_sq (inv_interval_sq_q),
		.valid_s2        (chain_valid[0]),
		.cell_s2         (chain_data[0])
	);

	for (genvar k = 0; k < Q_W; k++) begin : g_cell
		fbpk_div_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (advance),
			.prev_valid (chain_valid[k]),
			.prev_data  (chain_data[k]),
			.valid      (chain_valid[k+1]),
			.data       (chain_data[k+1])
		);
	end

	fbpk_out_buf u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.pipe_valid  (chain_valid[Q_W]),
		.pipe_data   (chain_data[Q_W]),
		.advance     (advance),
		.coef_valid  (coef_valid),
		.coef_ready  (coef_ready),
		.coefficient (coefficient)
	);

endmodule
